### sv/tsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token scanner package
// Shared types, token codes, the keyword table and the per-character
// scanning step of the token scanner.
// ----------------------------------------------------------------------------
package tsf_pkg;

    typedef enum logic [4:0] {
        S_INIT, S_ID, S_SLASH, S_LINECOM, S_BLKCOM, S_BLKSTAR, S_EQ, S_BANG,
        S_LESS, S_GREATER, S_STR, S_ESC, S_ZERO, S_BIN, S_BIN1, S_OCT, S_DEC,
        S_HEX, S_FRAC1, S_FRACN, S_EXP1, S_EXPSGN, S_EXPN
    } scan_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof_mark;
    } in_item_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  attr_char;
        logic        token_valid;
        logic [5:0]  token_type;
        logic [15:0] line_number;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        cv;
        logic [7:0]  ch;
        logic        tv;
        logic [5:0]  ty;
        logic        push;
        scan_state_t nxt;
    } action_t;

    localparam logic [5:0] T_ID     = 6'd0;
    localparam logic [5:0] T_ADD    = 6'd15;
    localparam logic [5:0] T_SUB    = 6'd16;
    localparam logic [5:0] T_MUL    = 6'd17;
    localparam logic [5:0] T_DIV    = 6'd18;
    localparam logic [5:0] T_ASSIGN = 6'd19;
    localparam logic [5:0] T_EQ     = 6'd20;
    localparam logic [5:0] T_NEQ    = 6'd21;
    localparam logic [5:0] T_LT     = 6'd22;
    localparam logic [5:0] T_LE     = 6'd23;
    localparam logic [5:0] T_GT     = 6'd24;
    localparam logic [5:0] T_GE     = 6'd25;
    localparam logic [5:0] T_OUT    = 6'd26;
    localparam logic [5:0] T_IN     = 6'd27;
    localparam logic [5:0] T_LCURLY = 6'd28;
    localparam logic [5:0] T_RCURLY = 6'd29;
    localparam logic [5:0] T_LPAR   = 6'd30;
    localparam logic [5:0] T_RPAR   = 6'd31;
    localparam logic [5:0] T_COMMA  = 6'd32;
    localparam logic [5:0] T_SEMI   = 6'd33;
    localparam logic [5:0] T_STR    = 6'd34;
    localparam logic [5:0] T_INT    = 6'd35;
    localparam logic [5:0] T_BIN    = 6'd36;
    localparam logic [5:0] T_OCT    = 6'd37;
    localparam logic [5:0] T_HEX    = 6'd38;
    localparam logic [5:0] T_DBL    = 6'd39;
    localparam logic [5:0] T_EOF    = 6'd41;
    localparam logic [5:0] T_ERR    = 6'd42;

    localparam int KW_COUNT = 14;
    localparam int KW_MAX   = 6;

    localparam logic [7:0] KW_CHR [KW_COUNT][KW_MAX] = '{
        '{"i", "n", "t", 8'd0, 8'd0, 8'd0},
        '{"d", "o", "u", "b", "l", "e"},
        '{"s", "t", "r", "i", "n", "g"},
        '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", 8'd0, 8'd0},
        '{"w", "h", "i", "l", "e", 8'd0},
        '{"c", "i", "n", 8'd0, 8'd0, 8'd0},
        '{"c", "o", "u", "t", 8'd0, 8'd0},
        '{"m", "a", "i", "n", 8'd0, 8'd0},
        '{"l", "e", "n", "g", "t", "h"},
        '{"f", "i", "n", "d", 8'd0, 8'd0},
        '{"s", "o", "r", "t", 8'd0, 8'd0},
        '{"c", "o", "n", "c", "a", "t"},
        '{"r", "e", "t", "u", "r", "n"}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd6, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4, 3'd6, 3'd4, 3'd4, 3'd6, 3'd6
    };

    function automatic logic is_digit(input logic eof, input logic [7:0] c);
        return !eof && c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic eof, input logic [7:0] c);
        return !eof && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
    endfunction

    function automatic logic is_xdigit(input logic eof, input logic [7:0] c);
        return is_digit(eof, c) || (!eof && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
    endfunction

    function automatic logic is_ch(input logic eof, input logic [7:0] c, input logic [7:0] x);
        return !eof && c == x;
    endfunction

    // One step of the scanning automaton; kw is the kind of the identifier held.
    function automatic action_t scan(input scan_state_t st, input logic eof,
                                     input logic [7:0] c, input logic [5:0] kw);
        action_t a;
        logic    dig;
        logic    ee;
        logic    sp;
        a    = '0;
        a.nxt = st;
        dig  = is_digit(eof, c);
        ee   = is_ch(eof, c, "e") || is_ch(eof, c, "E");
        sp   = !eof && (c == " " || (c >= 8'd9 && c <= 8'd13));
        unique case (st)
            S_INIT:
            begin
                if (sp)
                begin
                end
                else if (is_alpha(eof, c))
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_ID;
                end
                else if (is_ch(eof, c, "/")) a.nxt = S_SLASH;
                else if (is_ch(eof, c, "=")) a.nxt = S_EQ;
                else if (is_ch(eof, c, "<")) a.nxt = S_LESS;
                else if (is_ch(eof, c, ">")) a.nxt = S_GREATER;
                else if (is_ch(eof, c, "!")) a.nxt = S_BANG;
                else if (is_ch(eof, c, "\"")) a.nxt = S_STR;
                else if (is_ch(eof, c, "0"))
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_ZERO;
                end
                else if (is_ch(eof, c, "1"))
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_BIN1;
                end
                else if (dig)
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_DEC;
                end
                else
                begin
                    a.tv  = 1'b1;
                    a.nxt = S_INIT;
                    if (eof) a.ty = T_EOF;
                    else if (c == "+") a.ty = T_ADD;
                    else if (c == "-") a.ty = T_SUB;
                    else if (c == "*") a.ty = T_MUL;
                    else if (c == "{") a.ty = T_LCURLY;
                    else if (c == "}") a.ty = T_RCURLY;
                    else if (c == "(") a.ty = T_LPAR;
                    else if (c == ")") a.ty = T_RPAR;
                    else if (c == ",") a.ty = T_COMMA;
                    else if (c == ";") a.ty = T_SEMI;
                    else a.ty = T_ERR;
                end
            end
            S_ID:
            begin
                if (is_alpha(eof, c) || dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = kw; a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_SLASH:
            begin
                if (is_ch(eof, c, "/")) a.nxt = S_LINECOM;
                else if (is_ch(eof, c, "*")) a.nxt = S_BLKCOM;
                else
                begin
                    a.tv = 1'b1; a.ty = T_DIV; a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_LINECOM:
            begin
                if (is_ch(eof, c, 8'h0A)) a.nxt = S_INIT;
                else if (eof)
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
            end
            S_BLKCOM:
            begin
                if (is_ch(eof, c, "*")) a.nxt = S_BLKSTAR;
                else if (eof)
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
            end
            S_BLKSTAR:
            begin
                if (is_ch(eof, c, "*"))
                begin
                end
                else if (is_ch(eof, c, "/")) a.nxt = S_INIT;
                else if (eof)
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
                else a.nxt = S_BLKCOM;
            end
            S_EQ:
            begin
                a.tv = 1'b1; a.nxt = S_INIT;
                if (is_ch(eof, c, "=")) a.ty = T_EQ;
                else
                begin
                    a.ty = T_ASSIGN; a.push = 1'b1;
                end
            end
            S_BANG:
            begin
                a.tv = 1'b1; a.nxt = S_INIT;
                a.ty = is_ch(eof, c, "=") ? T_NEQ : T_ERR;
            end
            S_LESS:
            begin
                a.tv = 1'b1; a.nxt = S_INIT;
                if (is_ch(eof, c, "=")) a.ty = T_LE;
                else if (is_ch(eof, c, "<")) a.ty = T_OUT;
                else
                begin
                    a.ty = T_LT; a.push = 1'b1;
                end
            end
            S_GREATER:
            begin
                a.tv = 1'b1; a.nxt = S_INIT;
                if (is_ch(eof, c, "=")) a.ty = T_GE;
                else if (is_ch(eof, c, ">")) a.ty = T_IN;
                else
                begin
                    a.ty = T_GT; a.push = 1'b1;
                end
            end
            S_STR:
            begin
                if (is_ch(eof, c, "\\")) a.nxt = S_ESC;
                else if (is_ch(eof, c, "\""))
                begin
                    a.tv = 1'b1; a.ty = T_STR; a.nxt = S_INIT;
                end
                else if (eof || c <= 8'd31)
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
                else
                begin
                    a.cv = 1'b1; a.ch = c;
                end
            end
            S_ESC:
            begin
                a.nxt = S_STR;
                if (is_ch(eof, c, "t"))
                begin
                    a.cv = 1'b1; a.ch = 8'h09;
                end
                else if (is_ch(eof, c, "n"))
                begin
                    a.cv = 1'b1; a.ch = 8'h0A;
                end
                else if (is_ch(eof, c, "\\") || is_ch(eof, c, "\""))
                begin
                    a.cv = 1'b1; a.ch = c;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
            end
            S_ZERO:
            begin
                if (is_ch(eof, c, "x"))
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_HEX;
                end
                else if (is_ch(eof, c, "."))
                begin
                    a.cv = 1'b1; a.ch = "."; a.nxt = S_FRAC1;
                end
                else if (ee)
                begin
                    a.cv = 1'b1; a.ch = "e"; a.nxt = S_EXP1;
                end
                else if (dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                    a.nxt = (c <= "1") ? S_BIN : ((c <= "7") ? S_OCT : S_DEC);
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_INT; a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_BIN, S_BIN1:
            begin
                if (is_ch(eof, c, "."))
                begin
                    a.cv = 1'b1; a.ch = "."; a.nxt = S_FRAC1;
                end
                else if (ee)
                begin
                    a.cv = 1'b1; a.ch = "e"; a.nxt = S_EXP1;
                end
                else if (dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                    if (c > "1") a.nxt = (st == S_BIN && c <= "7") ? S_OCT : S_DEC;
                end
                else if (is_ch(eof, c, "b"))
                begin
                    a.cv = 1'b1; a.ch = c; a.tv = 1'b1; a.ty = T_BIN; a.nxt = S_INIT;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = (st == S_BIN) ? T_OCT : T_INT;
                    a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_OCT, S_DEC:
            begin
                if (is_ch(eof, c, "."))
                begin
                    a.cv = 1'b1; a.ch = "."; a.nxt = S_FRAC1;
                end
                else if (ee)
                begin
                    a.cv = 1'b1; a.ch = "e"; a.nxt = S_EXP1;
                end
                else if (dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                    if (c >= "8") a.nxt = S_DEC;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = (st == S_OCT) ? T_OCT : T_INT;
                    a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_HEX:
            begin
                if (is_xdigit(eof, c))
                begin
                    a.cv = 1'b1; a.ch = c;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_HEX; a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_FRAC1, S_EXPSGN:
            begin
                if (dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                    a.nxt = (st == S_FRAC1) ? S_FRACN : S_EXPN;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
            end
            S_FRACN:
            begin
                if (dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                end
                else if (ee)
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_EXP1;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_DBL; a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            S_EXP1:
            begin
                if (dig)
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_EXPN;
                end
                else if (is_ch(eof, c, "+") || is_ch(eof, c, "-"))
                begin
                    a.cv = 1'b1; a.ch = c; a.nxt = S_EXPSGN;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_ERR; a.nxt = S_INIT;
                end
            end
            S_EXPN:
            begin
                if (dig)
                begin
                    a.cv = 1'b1; a.ch = c;
                end
                else
                begin
                    a.tv = 1'b1; a.ty = T_DBL; a.push = 1'b1; a.nxt = S_INIT;
                end
            end
            default:
            begin
                a.nxt = S_INIT;
            end
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

### sv/tsf_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token scanner stream interface
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface tsf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/token_scanner_fsm_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token scanner unit
// Character-at-a-time lexical scanner with a two-entry result queue.
//
//   channel  direction  payload
//   chars    sink       ch, eof_mark
//   tokens   source     char_valid, attr_char, token_valid, token_type,
//                       line_number, last
//
// Each accepted character is scanned in the cycle it is accepted, including
// a pushed-back second pass, and its zero, one or two result beats enter the
// result queue. One character per cycle is sustained while the output takes
// every beat and each character gives at most one beat; one with two beats
// holds the input until its first is taken. Reset restores S_INIT, line 1.
// ----------------------------------------------------------------------------
module token_scanner_fsm_unit
    import tsf_pkg::*;
#(
    parameter int LINE_BITS     = 16,
    parameter int KEYWORD_CHARS = 6
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tsf_stream_if.sink   chars,
    tsf_stream_if.source tokens
);

    localparam int IW  = $clog2(KEYWORD_CHARS + 2);
    localparam int AW  = $clog2(KEYWORD_CHARS);
    localparam int EXT = (LINE_BITS > 16) ? LINE_BITS : 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    scan_state_t            state_reg, state_next;
    logic [7:0]             kbuf_reg [KEYWORD_CHARS];
    logic [IW-1:0]          ilen_reg, ilen_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    out_item_t              slot0_reg, slot1_reg;
    logic [1:0]             count_reg;

    logic        eof;
    logic [7:0]  c;
    logic [5:0]  kw;
    action_t     a1, a2;
    logic        has1, has2;
    logic        accept, pop;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [LINE_BITS-1:0] line_inc;
    logic [EXT-1:0] ext_pre, ext_inc;
    logic [15:0] ln_pre, ln_inc;
    out_item_t   r0, r1;
    logic [1:0]  n_res;
    logic        match;

    assign eof = chars.payload.eof_mark;
    assign c   = chars.payload.ch;

    always_comb
    begin
        kw = T_ID;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            match = (ilen_reg == IW'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX; j++)
            begin
                if (3'(j) < KW_LEN[k] && kbuf_reg[j] != KW_CHR[k][j])
                begin
                    match = 1'b0;
                end
            end
            if (match)
            begin
                kw = 6'(k + 1);
            end
        end
    end

    assign a1 = scan(state_reg, eof, c, kw);
    assign a2 = scan(S_INIT, eof, c, kw);

    assign line_inc = (is_ch(eof, c, 8'h0A) && line_reg != LINE_MAX) ?
                      line_reg + 1'b1 : line_reg;
    assign ext_pre  = EXT'(line_reg);
    assign ext_inc  = EXT'(line_inc);
    assign ln_pre   = ((ext_pre >> 16) != 0) ? 16'hFFFF : ext_pre[15:0];
    assign ln_inc   = ((ext_inc >> 16) != 0) ? 16'hFFFF : ext_inc[15:0];

    assign has1 = a1.cv || a1.tv;
    assign has2 = a1.push && (a2.cv || a2.tv);

    always_comb
    begin
        r0.char_valid  = a1.cv;
        r0.attr_char   = a1.cv ? a1.ch : 8'd0;
        r0.token_valid = a1.tv;
        r0.token_type  = a1.tv ? a1.ty : 6'd0;
        r0.line_number = a1.push ? ln_pre : ln_inc;
        r0.last        = !has2;
        r1.char_valid  = a2.cv;
        r1.attr_char   = a2.cv ? a2.ch : 8'd0;
        r1.token_valid = a2.tv;
        r1.token_type  = a2.tv ? a2.ty : 6'd0;
        r1.line_number = ln_inc;
        r1.last        = 1'b1;
        n_res          = has1 ? (has2 ? 2'd2 : 2'd1) : 2'd0;
    end

    always_comb
    begin
        state_next = a1.push ? a2.nxt : a1.nxt;
        line_next  = line_inc;
        ilen_next  = ilen_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        if (state_reg == S_ID)
        begin
            if (is_alpha(eof, c) || is_digit(eof, c))
            begin
                if (ilen_reg < IW'(KEYWORD_CHARS))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = ilen_reg[AW-1:0];
                    ilen_next = ilen_reg + 1'b1;
                end
                else
                begin
                    ilen_next = IW'(KEYWORD_CHARS + 1);
                end
            end
            else
            begin
                ilen_next = '0;
            end
        end
        else if ((state_reg == S_INIT || a1.push) && is_alpha(eof, c))
        begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            ilen_next = IW'(1);
        end
    end

    assign tokens.valid   = (count_reg != 2'd0);
    assign tokens.payload = slot0_reg;
    assign pop            = tokens.valid && tokens.ready;
    assign chars.ready    = (count_reg == 2'd0) || (count_reg == 2'd1 && tokens.ready);
    assign accept         = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ilen_reg  <= '0;
            line_reg  <= LINE_BITS'(1);
            count_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                ilen_reg  <= ilen_next;
                line_reg  <= line_next;
                count_reg <= n_res;
            end
            else if (pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot0_reg <= r0;
            slot1_reg <= r1;
            if (wr_en)
            begin
                kbuf_reg[wr_addr] <= c;
            end
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule
`default_nettype wire
